// ----- hdl/fes_pkg.sv -----
// Shared types, codes and reset values for the flash erase/program sequencer.
package fes_pkg;

  localparam int DATA_W      = 24;
  localparam int OFFSET_W    = 10;
  localparam int CHUNK_OUT_W = 9;
  localparam int PKT_LEN_W   = 11;
  localparam int CFG_IDX_W   = 2;

  // request functions
  localparam logic [1:0] FUNC_BEGIN = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_POLL  = 2'd2;
  localparam logic [1:0] FUNC_ABORT = 2'd3;

  // response status
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_REJECTED = 2'd1;
  localparam logic [1:0] ST_WRITTEN  = 2'd2;
  localparam logic [1:0] ST_FAILED   = 2'd3;

  // flash commands
  localparam logic [1:0] CMD_NONE        = 2'd0;
  localparam logic [1:0] CMD_ERASE       = 2'd1;
  localparam logic [1:0] CMD_PROGRAM     = 2'd2;
  localparam logic [1:0] CMD_READ_STATUS = 2'd3;

  // start outcomes; any other code is an error
  localparam logic [1:0] START_OK   = 2'd0;
  localparam logic [1:0] START_BUSY = 2'd1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STORE_ENABLED     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DATA_BASE_ADDRESS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_UPLOAD_SIZE   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PACKET_SIZE   = 2'd3;

  localparam logic [DATA_W-1:0]    RST_DATA_BASE_ADDRESS = 24'd12718080;
  localparam logic [DATA_W-1:0]    RST_MAX_UPLOAD_SIZE   = 24'd1048576;
  localparam logic [PKT_LEN_W-1:0] RST_MAX_PACKET_SIZE   = 11'd1024;

  typedef struct packed {
    logic                 store_enabled;
    logic [DATA_W-1:0]    data_base_address;
    logic [DATA_W-1:0]    max_upload_size;
    logic [PKT_LEN_W-1:0] max_packet_size;
  } cfg_t;

  typedef struct packed {
    logic [1:0]        func;
    logic [DATA_W-1:0] length;
    logic              lock_granted;
    logic [1:0]        start_result;
    logic              status_read_ok;
    logic              flash_in_progress;
  } item_t;

  typedef struct packed {
    logic [1:0]             status;
    logic                   lock_attempt;
    logic                   lock_release;
    logic [1:0]             command;
    logic [DATA_W-1:0]      flash_address;
    logic [OFFSET_W-1:0]    buffer_offset;
    logic [CHUNK_OUT_W-1:0] chunk_length;
    logic                   busy_res;
    logic [DATA_W-1:0]      written_bytes;
  } result_t;

endpackage

// ----- hdl/fes_req_if.sv -----
// Request channel: command word with flash feedback for one step.
interface fes_req_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                func;
  logic [fes_pkg::DATA_W-1:0] length;
  logic                      lock_granted;
  logic [1:0]                start_result;
  logic                      status_read_ok;
  logic                      flash_in_progress;

  modport source (
    output valid, func, length, lock_granted, start_result, status_read_ok,
           flash_in_progress,
    input  ready
  );
  modport sink (
    input  valid, func, length, lock_granted, start_result, status_read_ok,
           flash_in_progress,
    output ready
  );
endinterface

// ----- hdl/fes_rsp_if.sv -----
// Response channel: one result word per request word.
interface fes_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      status;
  logic                            lock_attempt;
  logic                            lock_release;
  logic [1:0]                      command;
  logic [fes_pkg::DATA_W-1:0]      flash_address;
  logic [fes_pkg::OFFSET_W-1:0]    buffer_offset;
  logic [fes_pkg::CHUNK_OUT_W-1:0] chunk_length;
  logic                            busy_res;
  logic [fes_pkg::DATA_W-1:0]      written_bytes;

  modport source (
    output valid, status, lock_attempt, lock_release, command, flash_address,
           buffer_offset, chunk_length, busy_res, written_bytes,
    input  ready
  );
  modport sink (
    input  valid, status, lock_attempt, lock_release, command, flash_address,
           buffer_offset, chunk_length, busy_res, written_bytes,
    output ready
  );
endinterface

// ----- hdl/fes_engine.sv -----
// Sequencer state and the single-pass next-state and result logic.
module fes_engine #(
  parameter int SECTOR_SHIFT = 12,
  parameter int PAGE_BYTES   = 256,
  parameter int PACKET_BYTES = 1024,
  parameter int ADDRESS_BITS = 24
) (
  input  logic             clk,
  input  logic             rst,
  input  fes_pkg::cfg_t    cfg,
  input  fes_pkg::item_t   item,
  input  logic             step,
  output fes_pkg::result_t res
);

  localparam int DW      = fes_pkg::DATA_W;
  localparam int SEC_W   = DW + 1 - SECTOR_SHIFT;
  localparam int CHUNK_W = $clog2(PAGE_BYTES + 1);
  localparam int AW      = (ADDRESS_BITS < DW) ? ADDRESS_BITS : DW;
  localparam logic [DW-1:0] ADDR_MASK  = DW'((64'd1 << AW) - 64'd1);
  localparam logic [DW-1:0] PAGE_LEN   = DW'(PAGE_BYTES);
  localparam logic [DW-1:0] PACKET_LEN = DW'(PACKET_BYTES);

  typedef enum logic [2:0] {
    PH_IDLE, PH_ERASE_KICK, PH_ERASE_WAIT, PH_PROG_KICK, PH_PROG_WAIT
  } phase_t;

  phase_t               phase, phase_next;
  logic                 lock_held, lock_held_next;
  logic [DW-1:0]        done_bytes, done_bytes_next;
  logic [DW-1:0]        total_bytes, total_bytes_next;
  logic [DW-1:0]        packet_start, packet_start_next;
  logic [DW-1:0]        packet_end, packet_end_next;
  logic [DW-1:0]        cursor, cursor_next;
  logic [CHUNK_W-1:0]   cur_chunk, cur_chunk_next;
  logic [SEC_W-1:0]     erase_next, erase_next_next;
  logic [SEC_W-1:0]     last_sector, last_sector_next;
  logic                 any_erased, any_erased_next;
  logic [SEC_W-1:0]     highest_erased, highest_erased_next;

  logic [DW:0]   write_sum;
  logic [DW-1:0] write_end;
  logic [DW-1:0] remaining;
  logic [DW-1:0] chunk;
  logic [DW-1:0] erase_addr;
  logic [DW-1:0] prog_addr;
  logic          write_bad;
  logic          held_now;
  logic          is_erase;
  logic          skip;

  always_comb begin
    write_sum  = {1'b0, done_bytes} + {1'b0, item.length};
    write_end  = write_sum[DW-1:0];
    remaining  = packet_end - cursor;
    chunk      = (remaining > PAGE_LEN) ? PAGE_LEN : remaining;
    erase_addr = (cfg.data_base_address + DW'({erase_next, {SECTOR_SHIFT{1'b0}}})) & ADDR_MASK;
    prog_addr  = (cfg.data_base_address + cursor) & ADDR_MASK;
    write_bad  = !cfg.store_enabled || (item.length == '0) ||
                 (item.length > DW'(cfg.max_packet_size)) || (item.length > PACKET_LEN) ||
                 (phase != PH_IDLE) || (write_sum > {1'b0, total_bytes});
    is_erase   = (phase == PH_ERASE_KICK);
    skip       = is_erase ? (erase_next > last_sector) : (cursor >= packet_end);
    held_now   = lock_held | item.lock_granted;

    phase_next          = phase;
    lock_held_next      = lock_held;
    done_bytes_next     = done_bytes;
    total_bytes_next    = total_bytes;
    packet_start_next   = packet_start;
    packet_end_next     = packet_end;
    cursor_next         = cursor;
    cur_chunk_next      = cur_chunk;
    erase_next_next     = erase_next;
    last_sector_next    = last_sector;
    any_erased_next     = any_erased;
    highest_erased_next = highest_erased;

    res = '0;
    res.status  = fes_pkg::ST_OK;
    res.command = fes_pkg::CMD_NONE;

    case (item.func)
      fes_pkg::FUNC_BEGIN: begin
        if (!cfg.store_enabled || (item.length == '0) ||
            (item.length > cfg.max_upload_size)) begin
          res.status = fes_pkg::ST_REJECTED;
        end else begin
          res.lock_release    = lock_held;
          phase_next          = PH_IDLE;
          lock_held_next      = 1'b0;
          done_bytes_next     = '0;
          total_bytes_next    = item.length;
          packet_start_next   = '0;
          packet_end_next     = '0;
          cursor_next         = '0;
          cur_chunk_next      = '0;
          erase_next_next     = '0;
          last_sector_next    = '0;
          any_erased_next     = 1'b0;
          highest_erased_next = '0;
        end
      end
      fes_pkg::FUNC_WRITE: begin
        if (write_bad) begin
          res.status = fes_pkg::ST_REJECTED;
        end else begin
          packet_start_next = done_bytes;
          packet_end_next   = write_end;
          last_sector_next  = SEC_W'((write_end - DW'(1)) >> SECTOR_SHIFT);
          erase_next_next   = any_erased ? highest_erased + SEC_W'(1)
                                         : SEC_W'(done_bytes >> SECTOR_SHIFT);
          cursor_next       = done_bytes;
          phase_next        = PH_ERASE_KICK;
        end
      end
      fes_pkg::FUNC_ABORT: begin
        res.lock_release    = lock_held;
        phase_next          = PH_IDLE;
        lock_held_next      = 1'b0;
        done_bytes_next     = '0;
        total_bytes_next    = '0;
        packet_start_next   = '0;
        packet_end_next     = '0;
        cursor_next         = '0;
        cur_chunk_next      = '0;
        erase_next_next     = '0;
        last_sector_next    = '0;
        any_erased_next     = 1'b0;
        highest_erased_next = '0;
      end
      default: begin
        if (cfg.store_enabled) begin
          unique case (phase)
            PH_ERASE_KICK, PH_PROG_KICK: begin
              if (skip) begin
                if (is_erase) begin
                  phase_next = PH_PROG_KICK;
                end else begin
                  done_bytes_next = packet_end;
                  phase_next      = PH_IDLE;
                  res.status      = fes_pkg::ST_WRITTEN;
                end
              end else begin
                res.lock_attempt = !lock_held;
                lock_held_next   = held_now;
                if (held_now) begin
                  if (is_erase) begin
                    res.command       = fes_pkg::CMD_ERASE;
                    res.flash_address = erase_addr;
                  end else begin
                    res.command       = fes_pkg::CMD_PROGRAM;
                    res.flash_address = prog_addr;
                    res.buffer_offset = fes_pkg::OFFSET_W'(cursor - packet_start);
                    res.chunk_length  = fes_pkg::CHUNK_OUT_W'(chunk);
                  end
                  if (item.start_result == fes_pkg::START_OK) begin
                    if (is_erase) begin
                      phase_next = PH_ERASE_WAIT;
                    end else begin
                      cur_chunk_next = CHUNK_W'(chunk);
                      phase_next     = PH_PROG_WAIT;
                    end
                  end else if (item.start_result != fes_pkg::START_BUSY) begin
                    // start error: give up the lock and abandon the packet
                    lock_held_next   = 1'b0;
                    res.lock_release = 1'b1;
                    phase_next       = PH_IDLE;
                    res.status       = fes_pkg::ST_FAILED;
                  end
                end
              end
            end
            PH_ERASE_WAIT, PH_PROG_WAIT: begin
              res.command = fes_pkg::CMD_READ_STATUS;
              if (item.status_read_ok && !item.flash_in_progress) begin
                lock_held_next   = 1'b0;
                res.lock_release = 1'b1;
                if (phase == PH_ERASE_WAIT) begin
                  highest_erased_next = erase_next;
                  any_erased_next     = 1'b1;
                  erase_next_next     = erase_next + SEC_W'(1);
                  phase_next          = PH_ERASE_KICK;
                end else begin
                  cursor_next = cursor + DW'(cur_chunk);
                  phase_next  = PH_PROG_KICK;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
    endcase

    res.busy_res      = (phase_next != PH_IDLE);
    res.written_bytes = done_bytes_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      lock_held      <= 1'b0;
      done_bytes     <= '0;
      total_bytes    <= '0;
      packet_start   <= '0;
      packet_end     <= '0;
      cursor         <= '0;
      cur_chunk      <= '0;
      erase_next     <= '0;
      last_sector    <= '0;
      any_erased     <= 1'b0;
      highest_erased <= '0;
    end else if (step) begin
      phase          <= phase_next;
      lock_held      <= lock_held_next;
      done_bytes     <= done_bytes_next;
      total_bytes    <= total_bytes_next;
      packet_start   <= packet_start_next;
      packet_end     <= packet_end_next;
      cursor         <= cursor_next;
      cur_chunk      <= cur_chunk_next;
      erase_next     <= erase_next_next;
      last_sector    <= last_sector_next;
      any_erased     <= any_erased_next;
      highest_erased <= highest_erased_next;
    end
  end

endmodule

// ----- hdl/flash_erase_program_sequencer_core.sv -----
// Erase-before-program upload sequencer for an SPI NOR data area. Each request word
// (begin, write, poll or abort, with the flash feedback for that step) yields exactly
// one response word. A word passes through an input register, one pass of next-state
// logic against the sequencer state, and a result register; a new word is taken every
// cycle while the response side keeps up, and the rate is set by that single next-state
// pass. Configuration registers are written through cfg_we/cfg_index/cfg_data and must
// only change while no word is in flight.
module flash_erase_program_sequencer_core #(
  parameter int SECTOR_SHIFT = 12,
  parameter int PAGE_BYTES   = 256,
  parameter int PACKET_BYTES = 1024,
  parameter int ADDRESS_BITS = 24
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [fes_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [fes_pkg::DATA_W-1:0]        cfg_data,
  fes_req_if.sink                           req,
  fes_rsp_if.source                         rsp
);

  fes_pkg::cfg_t    cfg;
  fes_pkg::item_t   s1_item;
  logic             s1_valid;
  fes_pkg::result_t eng_res;
  fes_pkg::result_t out_res;
  logic             out_valid;
  logic             out_free;
  logic             step;
  logic             req_take;

  assign out_free  = !out_valid || rsp.ready;
  assign step      = s1_valid && out_free;
  assign req.ready = !s1_valid || out_free;
  assign req_take  = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.store_enabled     <= 1'b0;
      cfg.data_base_address <= fes_pkg::RST_DATA_BASE_ADDRESS;
      cfg.max_upload_size   <= fes_pkg::RST_MAX_UPLOAD_SIZE;
      cfg.max_packet_size   <= fes_pkg::RST_MAX_PACKET_SIZE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fes_pkg::REG_STORE_ENABLED:     cfg.store_enabled     <= cfg_data[0];
        fes_pkg::REG_DATA_BASE_ADDRESS: cfg.data_base_address <= cfg_data;
        fes_pkg::REG_MAX_UPLOAD_SIZE:   cfg.max_upload_size   <= cfg_data;
        fes_pkg::REG_MAX_PACKET_SIZE:
          cfg.max_packet_size <= cfg_data[fes_pkg::PKT_LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // input register: load a new word, drop the old one once it steps
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_take) begin
      s1_valid <= 1'b1;
    end else if (step) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      s1_item.func              <= req.func;
      s1_item.length            <= req.length;
      s1_item.lock_granted      <= req.lock_granted;
      s1_item.start_result      <= req.start_result;
      s1_item.status_read_ok    <= req.status_read_ok;
      s1_item.flash_in_progress <= req.flash_in_progress;
    end
  end

  fes_engine #(
    .SECTOR_SHIFT (SECTOR_SHIFT),
    .PAGE_BYTES   (PAGE_BYTES),
    .PACKET_BYTES (PACKET_BYTES),
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_engine (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .item (s1_item),
    .step (step),
    .res  (eng_res)
  );

  // result register: hold until the response word is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res <= eng_res;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.status        = out_res.status;
  assign rsp.lock_attempt  = out_res.lock_attempt;
  assign rsp.lock_release  = out_res.lock_release;
  assign rsp.command       = out_res.command;
  assign rsp.flash_address = out_res.flash_address;
  assign rsp.buffer_offset = out_res.buffer_offset;
  assign rsp.chunk_length  = out_res.chunk_length;
  assign rsp.busy_res      = out_res.busy_res;
  assign rsp.written_bytes = out_res.written_bytes;

endmodule
